FILE: rtl/ltq_pkg.sv
// ----------------------------------------------------------------------------
// ltq_pkg
// Shared types and codes for the link task queue with duplicate suppression.
// ----------------------------------------------------------------------------
`default_nettype none

package ltq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam int CMD_W     = 2;
   localparam int KIND_W    = 2;
   localparam int LINK_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int FLOW_W    = 2;
   localparam int REMOVED_W = 5;
   localparam int ENTRY_W   = KIND_W + LINK_W;

   // commands
   localparam logic [CMD_W-1:0] CMD_ENQUEUE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXECUTE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_MATCH  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_POLLS  = 2'd3;

   // task kinds
   localparam logic [KIND_W-1:0] KIND_POLL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STOP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONT = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SKIP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

   // flow-control action
   localparam logic [FLOW_W-1:0] FLOW_NONE  = 2'd0;
   localparam logic [FLOW_W-1:0] FLOW_SET   = 2'd1;
   localparam logic [FLOW_W-1:0] FLOW_CLEAR = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [KIND_W-1:0] task_kind;
      logic [LINK_W-1:0] link_number;
      logic              high_priority;
      logic              role_switching;
      logic              link_connected;
      logic              has_sync_link;
      logic              tx_ok;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [KIND_W-1:0]    out_kind;
      logic [LINK_W-1:0]    out_link;
      logic [FLOW_W-1:0]    flow_action;
      logic [REMOVED_W-1:0] removed_count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/ltq_req_if.sv
// ----------------------------------------------------------------------------
// ltq_req_if
// Command channel: valid/ready handshake carrying one command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltq_req_if;
   logic             valid;
   logic             ready;
   ltq_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/ltq_rsp_if.sv
// ----------------------------------------------------------------------------
// ltq_rsp_if
// Result channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltq_rsp_if;
   logic             valid;
   logic             ready;
   ltq_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/ltq_ram.sv
// ----------------------------------------------------------------------------
// ltq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ltq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/link_task_queue_with_dedup_top.sv
// ----------------------------------------------------------------------------
// link_task_queue_with_dedup_top
// Ordered link task queue with duplicate suppression, held in one RAM ring.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one command per transaction (enqueue, execute head, delete
//   first match, delete all polls); rsp_if returns exactly one result per
//   command, in order. Both use valid/ready.
//   Queue entries live in a circular RAM (head pointer + count). Every command
//   that touches the queue runs one sweep over it through the RAM read port,
//   one entry per cycle, through its registered read; deletes compact the
//   ring in the same sweep through the write port. Commands rejected by the
//   admission checks and execute on an empty queue skip the sweep. The next
//   command can be accepted at the same edge at which the result can first
//   be taken. One command is in flight at a time; req_if.ready is high
//   while idle. A finished result sits in the output register; if rsp_if
//   stalls, the following result waits in the block until it frees.
//   Reset (synchronous) empties the queue; no clearing pass is needed since
//   only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module link_task_queue_with_dedup_top #(
   parameter int QUEUE_DEPTH = ltq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   ltq_req_if.sink   req_if,
   ltq_rsp_if.source rsp_if
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 rd_idx_ff, rd_idx_in;
   logic [CW-1:0]                 wr_idx_ff, wr_idx_in;
   logic [CW-1:0]                 limit_ff, limit_in;
   logic [CW-1:0]                 removed_ff, removed_in;
   logic                          dat_vld_ff, dat_vld_in;
   logic                          found_ff, found_in;
   ltq_pkg::req_type              cmd_ff, cmd_in;
   ltq_pkg::rsp_type              res_ff, res_in;
   ltq_pkg::rsp_type              out_ff, out_in;
   logic                          out_vld_ff, out_vld_in;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [AW-1:0]                 ram_raddr;
   logic [ltq_pkg::ENTRY_W-1:0]   ram_wdata;
   logic [ltq_pkg::ENTRY_W-1:0]   ram_rdata;
   logic [ltq_pkg::KIND_W-1:0]    rd_kind;
   logic [ltq_pkg::LINK_W-1:0]    rd_link;
   logic                          rd_match;
   logic                          req_fire;

   // logical queue position to ring address
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                               input logic [CW-1:0] idx);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(idx);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   ltq_ram #(
      .WIDTH (ltq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_kind  = ram_rdata[ltq_pkg::ENTRY_W-1:ltq_pkg::LINK_W];
   assign rd_link  = ram_rdata[ltq_pkg::LINK_W-1:0];
   assign rd_match = (rd_kind == cmd_ff.task_kind) && (rd_link == cmd_ff.link_number);

   assign req_if.ready   = (state_ff == S_IDLE);
   assign req_fire       = req_if.valid && req_if.ready;
   assign rsp_if.valid   = out_vld_ff;
   assign rsp_if.payload = out_ff;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      limit_in   = limit_ff;
      removed_in = removed_ff;
      dat_vld_in = 1'b0;
      found_in   = found_ff;
      cmd_in     = cmd_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_if.ready;
      ram_we     = 1'b0;
      ram_waddr  = ring_addr(head_ff, wr_idx_ff);
      ram_wdata  = ram_rdata;
      ram_raddr  = ring_addr(head_ff, rd_idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_if.payload;
               rd_idx_in  = '0;
               wr_idx_in  = '0;
               removed_in = '0;
               found_in   = 1'b0;
               res_in     = '0;
               limit_in   = (req_if.payload.command == ltq_pkg::CMD_EXECUTE)
                            ? CW'(1) : count_ff;
               state_in   = S_SCAN;
               case (req_if.payload.command)
                  ltq_pkg::CMD_ENQUEUE: begin
                     if (req_if.payload.task_kind != ltq_pkg::KIND_POLL &&
                         req_if.payload.task_kind != ltq_pkg::KIND_STOP &&
                         req_if.payload.task_kind != ltq_pkg::KIND_CONT) begin
                        res_in.status = ltq_pkg::ST_REFUSED;
                        state_in      = S_FIN;
                     end else if (req_if.payload.task_kind == ltq_pkg::KIND_POLL &&
                                  req_if.payload.role_switching) begin
                        res_in.status = ltq_pkg::ST_REFUSED;
                        state_in      = S_FIN;
                     end else if ((req_if.payload.task_kind == ltq_pkg::KIND_POLL &&
                                   !req_if.payload.link_connected) ||
                                  req_if.payload.has_sync_link) begin
                        res_in.status = ltq_pkg::ST_SKIP;
                        state_in      = S_FIN;
                     end
                  end
                  ltq_pkg::CMD_EXECUTE: begin
                     if (count_ff == '0) begin
                        res_in.status = ltq_pkg::ST_EMPTY;
                        state_in      = S_FIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // read side: one entry per cycle
            if (rd_idx_ff < limit_ff) begin
               rd_idx_in  = rd_idx_ff + CW'(1);
               dat_vld_in = 1'b1;
            end
            // data side: entry read last cycle
            if (dat_vld_ff) begin
               case (cmd_ff.command)
                  ltq_pkg::CMD_ENQUEUE: begin
                     if (rd_match) begin
                        found_in = 1'b1;
                     end
                  end
                  ltq_pkg::CMD_EXECUTE: begin
                     res_in.out_kind = rd_kind;
                     res_in.out_link = rd_link;
                  end
                  ltq_pkg::CMD_DEL_MATCH: begin
                     if (rd_match && !found_ff) begin
                        found_in   = 1'b1;
                        removed_in = removed_ff + CW'(1);
                     end else begin
                        ram_we    = 1'b1;
                        wr_idx_in = wr_idx_ff + CW'(1);
                     end
                  end
                  default: begin
                     if (rd_kind == ltq_pkg::KIND_POLL) begin
                        removed_in = removed_ff + CW'(1);
                     end else begin
                        ram_we    = 1'b1;
                        wr_idx_in = wr_idx_ff + CW'(1);
                     end
                  end
               endcase
            end
            // sweep finished: commit
            if (rd_idx_ff == limit_ff && !dat_vld_ff) begin
               state_in = S_FIN;
               case (cmd_ff.command)
                  ltq_pkg::CMD_ENQUEUE: begin
                     if (found_ff) begin
                        res_in.status = ltq_pkg::ST_SKIP;
                     end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                        res_in.status = ltq_pkg::ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {cmd_ff.task_kind, cmd_ff.link_number};
                        if (cmd_ff.high_priority) begin
                           head_in   = (head_ff == '0) ? AW'(QUEUE_DEPTH - 1)
                                                       : head_ff - AW'(1);
                           ram_waddr = head_in;
                        end else begin
                           ram_waddr = ring_addr(head_ff, count_ff);
                        end
                        count_in      = count_ff + CW'(1);
                        res_in.status = ltq_pkg::ST_DONE;
                     end
                  end
                  ltq_pkg::CMD_EXECUTE: begin
                     if (cmd_ff.tx_ok) begin
                        head_in  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head_ff + AW'(1);
                        count_in = count_ff - CW'(1);
                        res_in.status = ltq_pkg::ST_DONE;
                        if (res_ff.out_kind == ltq_pkg::KIND_STOP) begin
                           res_in.flow_action = ltq_pkg::FLOW_SET;
                        end else if (res_ff.out_kind == ltq_pkg::KIND_CONT) begin
                           res_in.flow_action = ltq_pkg::FLOW_CLEAR;
                        end else begin
                           res_in.flow_action = ltq_pkg::FLOW_NONE;
                        end
                     end else begin
                        res_in.status = ltq_pkg::ST_REFUSED;
                     end
                  end
                  ltq_pkg::CMD_DEL_MATCH: begin
                     count_in             = wr_idx_ff;
                     res_in.status        = found_ff ? ltq_pkg::ST_DONE : ltq_pkg::ST_SKIP;
                     res_in.removed_count = ltq_pkg::REMOVED_W'(removed_ff);
                  end
                  default: begin
                     count_in             = wr_idx_ff;
                     res_in.status        = ltq_pkg::ST_DONE;
                     res_in.removed_count = ltq_pkg::REMOVED_W'(removed_ff);
                  end
               endcase
            end
         end

         S_FIN: begin
            if (!out_vld_ff || rsp_if.ready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         dat_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         dat_vld_ff <= dat_vld_in;
         out_vld_ff <= out_vld_in;
      end
      rd_idx_ff  <= rd_idx_in;
      wr_idx_ff  <= wr_idx_in;
      limit_ff   <= limit_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff) == S_SCAN)
      else $error("queue count changed outside a sweep commit");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> wr_idx_ff <= rd_idx_ff)
      else $error("compaction write ran ahead of read");

   a_removed_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> removed_ff <= limit_ff)
      else $error("more entries removed than swept");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the link task queue: directed admission and queue
// cases, then random fill/drain/delete sequences under random handshake gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int QDEPTH       = ltq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int RANDOM_ITEMS = 1050;
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic [ltq_pkg::KIND_W-1:0] kind;
      logic [ltq_pkg::LINK_W-1:0] link;
   } task_entry_type;

   logic clock;
   logic reset;

   ltq_req_if req_bus ();
   ltq_rsp_if rsp_bus ();

   link_task_queue_with_dedup_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   task_entry_type   task_list[$];       // predicted queue contents, head at 0
   ltq_pkg::req_type cmd_backlog[$];     // commands not yet offered
   ltq_pkg::rsp_type pending_results[$]; // predicted results, oldest first

   int  n_queued   = 0;
   int  n_accepted = 0;
   int  fail_count = 0;
   logic req_fire;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic bit coin(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic ltq_pkg::req_type cmd_item(int cmd, int kind, int link, int hi,
                                                 int rs, int conn, int sync, int txok);
      ltq_pkg::req_type r;
      r.command        = cmd[ltq_pkg::CMD_W-1:0];
      r.task_kind      = kind[ltq_pkg::KIND_W-1:0];
      r.link_number    = link[ltq_pkg::LINK_W-1:0];
      r.high_priority  = hi[0];
      r.role_switching = rs[0];
      r.link_connected = conn[0];
      r.has_sync_link  = sync[0];
      r.tx_ok          = txok[0];
      return r;
   endfunction

   task automatic push_cmd(ltq_pkg::req_type r);
      cmd_backlog.push_back(r);
      n_queued++;
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued || pending_results.size() != 0)
         @(negedge clock);
   endtask

   // Updates task_list and returns the result the command must produce.
   function automatic ltq_pkg::rsp_type apply_command(ltq_pkg::req_type r);
      ltq_pkg::rsp_type res;
      task_entry_type   ent;
      bit               found;
      int               i;
      int               hits;
      res   = '0;
      found = 1'b0;
      hits  = 0;
      ent.kind = r.task_kind;
      ent.link = r.link_number;
      case (r.command)
         ltq_pkg::CMD_ENQUEUE: begin
            for (i = 0; i < task_list.size(); i++)
               if (task_list[i] == ent) found = 1'b1;
            if (r.task_kind > ltq_pkg::KIND_CONT)
               res.status = ltq_pkg::ST_REFUSED;
            else if (r.task_kind == ltq_pkg::KIND_POLL && r.role_switching)
               res.status = ltq_pkg::ST_REFUSED;
            else if (r.task_kind == ltq_pkg::KIND_POLL && !r.link_connected)
               res.status = ltq_pkg::ST_SKIP;
            else if (r.has_sync_link || found)
               res.status = ltq_pkg::ST_SKIP;
            else if (task_list.size() >= QDEPTH)
               res.status = ltq_pkg::ST_FULL;
            else begin
               if (r.high_priority) task_list.push_front(ent);
               else task_list.push_back(ent);
               res.status = ltq_pkg::ST_DONE;
            end
         end
         ltq_pkg::CMD_EXECUTE: begin
            if (task_list.size() == 0) begin
               res.status = ltq_pkg::ST_EMPTY;
            end else begin
               res.out_kind = task_list[0].kind;
               res.out_link = task_list[0].link;
               if (r.tx_ok) begin
                  if (task_list[0].kind == ltq_pkg::KIND_STOP)
                     res.flow_action = ltq_pkg::FLOW_SET;
                  else if (task_list[0].kind == ltq_pkg::KIND_CONT)
                     res.flow_action = ltq_pkg::FLOW_CLEAR;
                  else
                     res.flow_action = ltq_pkg::FLOW_NONE;
                  void'(task_list.pop_front());
                  res.status = ltq_pkg::ST_DONE;
               end else begin
                  res.status = ltq_pkg::ST_REFUSED;
               end
            end
         end
         ltq_pkg::CMD_DEL_MATCH: begin
            res.status = ltq_pkg::ST_SKIP;
            for (i = 0; i < task_list.size() && !found; i++) begin
               if (task_list[i] == ent) begin
                  task_list.delete(i);
                  found = 1'b1;
                  res.removed_count = ltq_pkg::REMOVED_W'(1);
                  res.status = ltq_pkg::ST_DONE;
               end
            end
         end
         default: begin
            i = 0;
            while (i < task_list.size()) begin
               if (task_list[i].kind == ltq_pkg::KIND_POLL) begin
                  task_list.delete(i);
                  hits++;
               end else begin
                  i++;
               end
            end
            res.removed_count = hits[ltq_pkg::REMOVED_W-1:0];
            res.status = ltq_pkg::ST_DONE;
         end
      endcase
      return res;
   endfunction

   // Driver: offers commands and toggles result backpressure on falling edges.
   always @(negedge clock) begin
      bit quiet;
      quiet = (n_accepted >= 400 && n_accepted < 560);
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= quiet || !coin(7);
         if (!req_bus.valid || req_fire) begin
            if (cmd_backlog.size() != 0 && (quiet || !coin(7))) begin
               req_bus.payload <= cmd_backlog.pop_front();
               req_bus.valid   <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks results, then predicts for the command taken this edge.
   always @(posedge clock) begin
      ltq_pkg::rsp_type want;
      ltq_pkg::rsp_type got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] result with nothing expected: %p", $time, got);
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status || got.out_kind !== want.out_kind ||
                   got.out_link !== want.out_link ||
                   got.flow_action !== want.flow_action ||
                   got.removed_count !== want.removed_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("[%0t] mismatch: expected %p, got %p", $time, want, got);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_results.push_back(apply_command(req_bus.payload));
            n_accepted++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("link_task_queue_with_dedup_top test failed");
      $finish;
   end

   initial begin
      int n_rand;
      int pick;
      int span;
      int len;
      int k;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      reset           = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty queue, admission checks, priority, deletes
      push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE,   ltq_pkg::KIND_POLL, 0,  0, 0, 1, 0, 1));
      push_cmd(cmd_item(ltq_pkg::CMD_DEL_MATCH, ltq_pkg::KIND_POLL, 0,  0, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_DEL_POLLS, ltq_pkg::KIND_POLL, 0,  0, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_POLL, 0,  0, 1, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_POLL, 0,  0, 0, 0, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_STOP, 15, 0, 0, 1, 1, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   3,                  5,  0, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_POLL, 0,  0, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_POLL, 0,  1, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_STOP, 15, 1, 1, 0, 0, 1));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_CONT, 7,  0, 0, 0, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE,   ltq_pkg::KIND_POLL, 0,  0, 0, 0, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE,   ltq_pkg::KIND_POLL, 0,  0, 0, 0, 0, 1));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_POLL, 15, 0, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_DEL_MATCH, ltq_pkg::KIND_POLL, 15, 0, 0, 0, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_DEL_MATCH, ltq_pkg::KIND_CONT, 3,  0, 0, 0, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE,   ltq_pkg::KIND_POLL, 9,  1, 0, 1, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_DEL_POLLS, ltq_pkg::KIND_STOP, 0,  0, 0, 0, 0, 0));
      push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE,   ltq_pkg::KIND_POLL, 0,  0, 0, 0, 0, 1));
      push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE,   ltq_pkg::KIND_POLL, 0,  0, 0, 0, 0, 1));
      wait_drained();

      // first random sequence: overfill an empty queue
      n_rand = 0;
      for (k = 0; k < QDEPTH + 2; k++) begin
         if (k < QDEPTH)
            push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE, $urandom_range(2), k,
                              $urandom_range(1), 0, 1, 0, $urandom_range(1)));
         else
            push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE, ltq_pkg::KIND_CONT,
                              $urandom_range(15), 0, 0, 1, 0, 0));
         n_rand++;
      end

      while (n_rand < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         span = coin(40) ? 3 : 15;
         if (pick < 32) begin
            // mostly admissible enqueues
            len = $urandom_range(20, 4);
            for (k = 0; k < len; k++)
               push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE, $urandom_range(2),
                                 $urandom_range(span), coin(30), coin(6), !coin(6),
                                 coin(6), $urandom_range(1)));
         end else if (pick < 57) begin
            len = $urandom_range(12, 2);
            for (k = 0; k < len; k++)
               push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE, $urandom_range(3),
                                 $urandom_range(15), $urandom_range(1),
                                 $urandom_range(1), $urandom_range(1),
                                 $urandom_range(1), !coin(20)));
         end else if (pick < 72) begin
            len = $urandom_range(4, 1);
            for (k = 0; k < len; k++)
               push_cmd(cmd_item(coin(75) ? ltq_pkg::CMD_DEL_MATCH : ltq_pkg::CMD_DEL_POLLS,
                                 $urandom_range(3), $urandom_range(span),
                                 $urandom_range(1), $urandom_range(1), $urandom_range(1),
                                 $urandom_range(1), $urandom_range(1)));
         end else if (pick < 78) begin
            // empty the queue, fill it with polls only, then sweep them out
            len = 2 * QDEPTH + 2;
            for (k = 0; k <= QDEPTH; k++)
               push_cmd(cmd_item(ltq_pkg::CMD_EXECUTE, ltq_pkg::KIND_POLL,
                                 0, 0, 0, 0, 0, 1));
            for (k = 0; k < QDEPTH; k++)
               push_cmd(cmd_item(ltq_pkg::CMD_ENQUEUE, ltq_pkg::KIND_POLL, k,
                                 $urandom_range(1), 0, 1, 0, 0));
            push_cmd(cmd_item(ltq_pkg::CMD_DEL_POLLS, $urandom_range(3),
                              $urandom_range(15), 0, 0, 0, 0, 0));
         end else begin
            len = $urandom_range(10, 1);
            for (k = 0; k < len; k++)
               push_cmd(cmd_item($urandom_range(3), $urandom_range(3), $urandom_range(15),
                                 $urandom_range(1), $urandom_range(1), $urandom_range(1),
                                 $urandom_range(1), $urandom_range(1)));
         end
         n_rand += len;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("link_task_queue_with_dedup_top test passed");
      else
         $display("link_task_queue_with_dedup_top test failed");
      $finish;
   end

endmodule

`default_nettype wire
